>>> hdl/sgsb_pkg.sv
// Package for the laser scan gap segmentation block.
// Holds the fixed field widths, limits and queue sizes; no dependencies.
package sgsb_pkg;

   // Fixed field widths of the item and result channels.
   localparam int GAP_W   = 16;
   localparam int ID_W    = 11;
   localparam int COUNT_W = 12;

   // Saturation limits for the cluster id and the member count.
   localparam logic [ID_W-1:0]    ID_MAX      = '1;
   localparam logic [COUNT_W-1:0] COUNT_LIMIT = '1;

   // Reset value of the gap threshold and of its square.
   localparam logic [GAP_W-1:0]   GAP_RESET    = 16'd300;
   localparam logic [2*GAP_W-1:0] GAP_SQ_RESET = 32'd90000;

   // Result queue: four entries; an item can give two results.
   localparam int Q_DEPTH = 4;
   localparam int Q_AW    = 2;

endpackage

>>> hdl/scan_gap_segmentation_bbox_core.sv
// Top level of the laser scan gap segmentation block with bounding boxes.
// Depends on sgsb_pkg for field widths, limits and queue sizing.

// Breakpoint segmentation of a laser scan: points come in scan order, one item
// per cycle at most, and each point joins the open cluster when its squared
// distance to the previous point is at most the squared gap threshold. A
// breaking point closes the open cluster (one result) and starts the next; the
// scan_last point flushes the open cluster (a result with scan_done set) and
// restarts the ids, so one item gives zero, one or two results. The pipeline is
// an input register, a stage that registers the two squared coordinate
// differences (one 16x16 multiplier each), and the cluster update stage that
// compares the sum against the squared threshold and writes the results into a
// four-entry result queue. Items are accepted every cycle as long as the queue
// has room for two more results; a run of items that each give two results is
// held back by the single result port. The threshold register may be written
// whenever no item is in the block; its square is formed on the write.
module scan_gap_segmentation_bbox_core #(
   parameter int MAX_POINTS = 2048,
   parameter int COORD_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   // Point items
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [COORD_BITS-1:0]       req_point_x,
   input  logic signed [COORD_BITS-1:0]       req_point_y,
   input  logic                               req_scan_last,
   // Cluster results
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [sgsb_pkg::ID_W-1:0]          rsp_cluster_id,
   output logic signed [COORD_BITS-1:0]       rsp_center_x,
   output logic signed [COORD_BITS-1:0]       rsp_center_y,
   output logic [COORD_BITS-1:0]              rsp_box_width,
   output logic [COORD_BITS-1:0]              rsp_box_height,
   output logic [sgsb_pkg::COUNT_W-1:0]       rsp_member_count,
   output logic                               rsp_scan_done,
   // Gap threshold register
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [sgsb_pkg::GAP_W-1:0]         csr_gap_threshold_mm
);
   import sgsb_pkg::*;

   localparam int CB = COORD_BITS;
   localparam int DW = (CB > GAP_W) ? CB : GAP_W;
   localparam logic [COUNT_W-1:0] COUNT_CAP =
      (MAX_POINTS < int'(COUNT_LIMIT)) ? COUNT_W'(MAX_POINTS) : COUNT_LIMIT;

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic signed [CB-1:0] min_x;
      logic signed [CB-1:0] max_x;
      logic signed [CB-1:0] min_y;
      logic signed [CB-1:0] max_y;
      logic [COUNT_W-1:0] count;
      logic               done;
   } cluster_type;

   // Configuration registers.
   logic [GAP_W-1:0]    gap_ff;
   logic [2*GAP_W-1:0]  gap_sq_ff;

   // Input register.
   logic                 s1_valid_ff, s1_valid_in;
   logic signed [CB-1:0] s1_x_ff, s1_y_ff;
   logic                 s1_last_ff;

   // Previous point and whether a cluster is open for the next item.
   logic signed [CB-1:0] prev_x_ff, prev_y_ff;
   logic                 open_pred_ff;

   // Square stage.
   logic                 s2_valid_ff, s2_valid_in;
   logic signed [CB-1:0] s2_x_ff, s2_y_ff;
   logic                 s2_last_ff, s2_open_ff, s2_in_gap_ff;
   logic [2*GAP_W-1:0]   s2_sqx_ff, s2_sqy_ff;

   // Open cluster state.
   logic signed [CB-1:0] box_min_x_ff, box_max_x_ff, box_min_y_ff, box_max_y_ff;
   logic [COUNT_W-1:0]   open_count_ff;
   logic [ID_W-1:0]      next_id_ff;

   // Result queue.
   cluster_type          q_ff [Q_DEPTH];
   logic [Q_AW-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [Q_AW:0]        q_count_ff, q_count_in;

   logic                 s1_move, adv2, space, pop, req_accept;
   logic signed [CB:0]   diff_x, diff_y;
   logic [CB-1:0]        dx, dy;
   logic [DW-1:0]        dx_ext, dy_ext;
   logic                 in_gap;
   logic [GAP_W-1:0]     dx_n, dy_n;
   logic [2*GAP_W:0]     sq_sum;
   logic                 near, join_pt, emit_brk;
   logic signed [CB-1:0] nb_min_x, nb_max_x, nb_min_y, nb_max_y;
   logic [COUNT_W-1:0]   new_count;
   logic [ID_W-1:0]      id_after_brk;
   logic [1:0]           push_n;
   cluster_type          res_brk, res_last, res_first, head;

   // Handshake and pipeline advance.
   assign space      = q_count_ff <= (Q_AW+1)'(Q_DEPTH - 2);
   assign adv2       = s2_valid_ff && space;
   assign s1_move    = s1_valid_ff && (!s2_valid_ff || adv2);
   assign req_ready  = !s1_valid_ff || s1_move;
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;
   assign pop        = rsp_valid && rsp_ready;

   assign s1_valid_in = req_accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
   assign s2_valid_in = s1_move ? 1'b1 : (adv2 ? 1'b0 : s2_valid_ff);

   // Absolute coordinate differences to the previous point and their squares.
   always_comb begin
      diff_x = {s1_x_ff[CB-1], s1_x_ff} - {prev_x_ff[CB-1], prev_x_ff};
      diff_y = {s1_y_ff[CB-1], s1_y_ff} - {prev_y_ff[CB-1], prev_y_ff};
      dx     = diff_x[CB] ? CB'(-diff_x) : diff_x[CB-1:0];
      dy     = diff_y[CB] ? CB'(-diff_y) : diff_y[CB-1:0];
      dx_ext = DW'(dx);
      dy_ext = DW'(dy);
      in_gap = (dx_ext <= DW'(gap_ff)) && (dy_ext <= DW'(gap_ff));
      dx_n   = dx_ext[GAP_W-1:0];
      dy_n   = dy_ext[GAP_W-1:0];
   end

   // Gap test and the updated bounding box of the open cluster.
   always_comb begin
      sq_sum   = {1'b0, s2_sqx_ff} + {1'b0, s2_sqy_ff};
      near     = s2_in_gap_ff && (sq_sum <= {1'b0, gap_sq_ff});
      join_pt  = s2_open_ff && near;
      emit_brk = s2_open_ff && !near;
      if (join_pt) begin
         nb_min_x  = (s2_x_ff < box_min_x_ff) ? s2_x_ff : box_min_x_ff;
         nb_max_x  = (s2_x_ff > box_max_x_ff) ? s2_x_ff : box_max_x_ff;
         nb_min_y  = (s2_y_ff < box_min_y_ff) ? s2_y_ff : box_min_y_ff;
         nb_max_y  = (s2_y_ff > box_max_y_ff) ? s2_y_ff : box_max_y_ff;
         new_count = (open_count_ff < COUNT_CAP) ?
                     open_count_ff + COUNT_W'(1) : open_count_ff;
      end else begin
         nb_min_x  = s2_x_ff;
         nb_max_x  = s2_x_ff;
         nb_min_y  = s2_y_ff;
         nb_max_y  = s2_y_ff;
         new_count = COUNT_W'(1);
      end
      id_after_brk = (emit_brk && (next_id_ff < ID_MAX)) ?
                     next_id_ff + ID_W'(1) : next_id_ff;
   end

   // Results of this item: the broken cluster, then the flushed one.
   always_comb begin
      res_brk.id     = next_id_ff;
      res_brk.min_x  = box_min_x_ff;
      res_brk.max_x  = box_max_x_ff;
      res_brk.min_y  = box_min_y_ff;
      res_brk.max_y  = box_max_y_ff;
      res_brk.count  = open_count_ff;
      res_brk.done   = 1'b0;
      res_last.id    = id_after_brk;
      res_last.min_x = nb_min_x;
      res_last.max_x = nb_max_x;
      res_last.min_y = nb_min_y;
      res_last.max_y = nb_max_y;
      res_last.count = new_count;
      res_last.done  = 1'b1;
      res_first      = emit_brk ? res_brk : res_last;
      push_n         = adv2 ? ({1'b0, emit_brk} + {1'b0, s2_last_ff}) : 2'd0;
   end

   assign q_count_in = q_count_ff + (Q_AW+1)'(push_n) - (Q_AW+1)'(pop);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff        <= GAP_RESET;
         gap_sq_ff     <= GAP_SQ_RESET;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         open_pred_ff  <= 1'b0;
         prev_x_ff     <= '0;
         prev_y_ff     <= '0;
         open_count_ff <= '0;
         next_id_ff    <= '0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         q_count_ff    <= '0;
      end else begin
         if (csr_valid) begin
            gap_ff    <= csr_gap_threshold_mm;
            gap_sq_ff <= csr_gap_threshold_mm * csr_gap_threshold_mm;
         end
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         if (s1_move) begin
            open_pred_ff <= !s1_last_ff;
            prev_x_ff    <= s1_x_ff;
            prev_y_ff    <= s1_y_ff;
         end
         if (adv2) begin
            open_count_ff <= s2_last_ff ? '0 : new_count;
            next_id_ff    <= s2_last_ff ? '0 : id_after_brk;
         end
         wr_ptr_ff  <= wr_ptr_ff + Q_AW'(push_n);
         rd_ptr_ff  <= rd_ptr_ff + Q_AW'(pop);
         q_count_ff <= q_count_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_x_ff    <= req_point_x;
         s1_y_ff    <= req_point_y;
         s1_last_ff <= req_scan_last;
      end
      if (s1_move) begin
         s2_x_ff      <= s1_x_ff;
         s2_y_ff      <= s1_y_ff;
         s2_last_ff   <= s1_last_ff;
         s2_open_ff   <= open_pred_ff;
         s2_in_gap_ff <= in_gap;
         s2_sqx_ff    <= dx_n * dx_n;
         s2_sqy_ff    <= dy_n * dy_n;
      end
      if (adv2) begin
         box_min_x_ff <= nb_min_x;
         box_max_x_ff <= nb_max_x;
         box_min_y_ff <= nb_min_y;
         box_max_y_ff <= nb_max_y;
      end
      if (push_n != 2'd0) begin
         q_ff[wr_ptr_ff] <= res_first;
      end
      if (push_n == 2'd2) begin
         q_ff[wr_ptr_ff + Q_AW'(1)] <= res_last;
      end
   end

   // Result port: box size and center are formed from the queued extremes.
   assign head             = q_ff[rd_ptr_ff];
   assign rsp_valid        = q_count_ff != '0;
   assign rsp_cluster_id   = head.id;
   assign rsp_box_width    = CB'(head.max_x - head.min_x);
   assign rsp_box_height   = CB'(head.max_y - head.min_y);
   assign rsp_center_x     = $signed($unsigned(head.min_x) + (rsp_box_width >> 1));
   assign rsp_center_y     = $signed($unsigned(head.min_y) + (rsp_box_height >> 1));
   assign rsp_member_count = head.count;
   assign rsp_scan_done    = head.done;

`ifndef NO_ASSERTIONS
   // The result queue never holds more than its depth.
   a_q_bound: assert property (@(posedge clock) disable iff (reset)
      q_count_ff <= (Q_AW+1)'(Q_DEPTH))
      else $error("result queue overflow");

   // Every cluster shown on the result port has at least one member.
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_member_count != '0))
      else $error("result with empty cluster");

   // The last point of a scan restarts ids and leaves no open cluster.
   a_scan_end: assert property (@(posedge clock) disable iff (reset)
      (adv2 && s2_last_ff) |=> ((next_id_ff == '0) && (open_count_ff == '0)))
      else $error("scan end did not clear cluster state");

   // Any other point leaves a cluster open.
   a_open_after: assert property (@(posedge clock) disable iff (reset)
      (adv2 && !s2_last_ff) |=> (open_count_ff != '0))
      else $error("no cluster open after a point");

   // Input stalls only when both pipeline stages are occupied.
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && s2_valid_ff))
      else $error("input stalled with a free stage");
`endif

endmodule
